// File: sv/rkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rkt_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_WORDS_DEF   = 4;
   localparam int WORD_BITS       = 64;
   localparam int COUNT_BITS      = 7;

   localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      STATUS_FRESH = 2'd0,
      STATUS_DUP   = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// File: sv/rkt_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rkt_key_mem
   import rkt_pkg::*;
#(
   parameter int DEPTH      = TABLE_DEPTH_DEF,
   parameter int ADDR_BITS  = 6,
   parameter int DATA_BITS  = KEY_WORDS_DEF * WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/rkt_scan_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module rkt_scan_fsm
   import rkt_pkg::*;
#(
   parameter int ADDR_BITS = 6,
   parameter int KEY_BITS  = KEY_WORDS_DEF * WORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic [COUNT_BITS-1:0] limit,
   input  wire logic                  start,
   input  wire logic                  action,
   input  wire logic [KEY_BITS-1:0]   key,
   output logic                       ready,
   output logic                       mem_rd_en,
   output logic      [ADDR_BITS-1:0]  mem_rd_addr,
   input  wire logic [KEY_BITS-1:0]   mem_rd_data,
   output logic                       mem_wr_en,
   output logic      [ADDR_BITS-1:0]  mem_wr_addr,
   output logic      [KEY_BITS-1:0]   mem_wr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output status_type                 rsp_status,
   output logic      [COUNT_BITS-1:0] rsp_count
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   status_type            status_ff, status_in;
   logic                  act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  rsp_vld_ff, rsp_vld_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic issue;
   logic hit;
   logic out_free;

   assign issue    = idx_ff < count_ff;
   assign hit      = rd_vld_ff && (mem_rd_data == key_ff);
   assign out_free = !rsp_vld_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      status_in     = status_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of entry idx issued now, compared in the next cycle
            if (hit) begin
               status_in = STATUS_DUP;
               state_in  = ST_DONE;
            end else if (issue) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               status_in = STATUS_FRESH;
               if (act_ff) begin
                  if (count_ff >= limit) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + COUNT_BITS'(1);
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (start && state_ff == ST_IDLE) begin
         act_ff <= action;
         key_ff <= key;
      end
   end

   assign ready       = state_ff == ST_IDLE;
   assign mem_rd_addr = ADDR_BITS'(idx_ff);
   assign mem_wr_addr = ADDR_BITS'(count_ff);
   assign mem_wr_data = key_ff;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;

endmodule

`default_nettype wire

// File: sv/replay_key_table_top.sv
// rsp_tvalid rises after the request beat once the scan over the keys held has ended
//   and the result is registered; a duplicate ends the scan at its matching entry.
// Requests are taken one at a time; the scan reads one stored key per cycle from the
//   single key memory.
// A response waiting in the output register does not block the next request beat.
// Reset (sync, active high) empties the table, limit 64; a csr write empties it too.
`timescale 1ns / 1ps
`default_nettype none

module replay_key_table_top
   import rkt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_WORDS   = KEY_WORDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // req_tdata: key_word0 [63:0], key_word1 [127:64], key_word2 [191:128],
   //            key_word3 [255:192]
   input  wire logic [4*WORD_BITS-1:0] req_tdata,
   // req_tuser: action [0] (0 check, 1 consume)
   input  wire logic                  req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata: status [1:0], stored_count [8:2], zero [15:9]
   output logic      [15:0]           rsp_tdata,
   // table_limit register
   input  wire logic                  csr_we,
   input  wire logic [COUNT_BITS-1:0] csr_wdata
);

   localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_BITS  = KEY_WORDS * WORD_BITS;

   // limit saturates at the storage size (and at what the count field holds)
   localparam logic [COUNT_BITS-1:0] DEPTH_CAP =
      (TABLE_DEPTH > (2**COUNT_BITS - 1)) ? COUNT_BITS'(2**COUNT_BITS - 1)
                                          : COUNT_BITS'(TABLE_DEPTH);
   localparam logic [COUNT_BITS-1:0] LIMIT_RESET_EFF =
      (LIMIT_RESET > DEPTH_CAP) ? DEPTH_CAP : LIMIT_RESET;

   logic [COUNT_BITS-1:0] limit_ff, limit_in;

   logic                  ready;
   logic                  req_accept;
   logic                  mem_rd_en;
   logic [ADDR_BITS-1:0]  mem_rd_addr;
   logic [KEY_BITS-1:0]   mem_rd_data;
   logic                  mem_wr_en;
   logic [ADDR_BITS-1:0]  mem_wr_addr;
   logic [KEY_BITS-1:0]   mem_wr_data;
   logic                  rsp_valid;
   status_type            rsp_status;
   logic [COUNT_BITS-1:0] rsp_count;

   // effective limit kept, clamped once on the write
   always_comb begin
      limit_in = limit_ff;
      if (csr_we) begin
         limit_in = (csr_wdata > DEPTH_CAP) ? DEPTH_CAP : csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET_EFF;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_tready = ready;
   assign req_accept = req_tvalid && ready;

   // Scan control: one stored key read per cycle, compare on the returned data.
   // The append write lands before the next request's first read, with the DONE
   // and IDLE states between them, so no forwarding is needed.
   rkt_scan_fsm #(
      .ADDR_BITS (ADDR_BITS),
      .KEY_BITS  (KEY_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_we),
      .limit       (limit_ff),
      .start       (req_accept),
      .action      (req_tuser),
      .key         (req_tdata[KEY_BITS-1:0]),
      .ready       (ready),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   // Consumed-key store, one full key per entry
   rkt_key_mem #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (KEY_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {7'd0, rsp_count, rsp_status};

   // a request beat closes the door until its scan is finished
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while a scan was running");

   // the table never grows past the limit
   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= limit_ff))
      else $error("stored count above limit");

   // full is only reported when the table has reached the limit
   a_full_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == STATUS_FULL) |-> (rsp_count == limit_ff))
      else $error("full reported below limit");

   // appends only land below the limit, so a zero limit never writes
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (COUNT_BITS'(mem_wr_addr) < limit_ff))
      else $error("append at or beyond the limit");

endmodule

`default_nettype wire
